@@ rtl/kls_pkg.sv @@
// kls_pkg: shared types, token kind codes and byte helpers for the keyword lexer
// no dependencies

package kls_pkg;

   typedef enum logic [2:0] {
      CLS_END,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_SPACE,
      CLS_OTHER
   } cls_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_NUM,
      PEND_IDENT
   } pend_type;

   typedef enum logic [1:0] {
      KW_IF,
      KW_ELSE,
      KW_WHILE,
      KW_FOR
   } kw_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_CHAR,
      ST_POST,
      ST_TOKEN
   } state_type;

   localparam int KIND_W = 5;
   localparam int BYTE_W = 8;
   localparam int NUM_KW = 4;

   localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd2;
   localparam logic [KIND_W-1:0] KIND_IF      = 5'd3;
   localparam logic [KIND_W-1:0] KIND_ELSE    = 5'd4;
   localparam logic [KIND_W-1:0] KIND_WHILE   = 5'd5;
   localparam logic [KIND_W-1:0] KIND_FOR     = 5'd6;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd7;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_STAR    = 5'd9;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd10;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd11;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd12;
   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd13;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd14;
   localparam logic [KIND_W-1:0] KIND_COLON   = 5'd15;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd16;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd17;

   typedef struct packed {
      logic latch;
      logic append;
      logic start;
      logic clear;
      logic rd_start;
      logic rd_next;
      logic rd_en;
      logic sel_token;
      logic more;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    pend_active;
      logic    cont;
      logic    will_fill;
      logic    token_end;
   } status_type;

   function automatic cls_type classify(logic [BYTE_W-1:0] c);
      cls_type r;
      if (c == 8'h00) begin
         r = CLS_END;
      end else if (c >= "0" && c <= "9") begin
         r = CLS_DIGIT;
      end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
         r = CLS_ALPHA;
      end else if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
         r = CLS_SPACE;
      end else begin
         r = CLS_OTHER;
      end
      return r;
   endfunction

   function automatic logic [KIND_W-1:0] byte_kind(logic [BYTE_W-1:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         8'h00:   k = KIND_END;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "=":     k = KIND_ASSIGN;
         ";":     k = KIND_SEMI;
         ":":     k = KIND_COLON;
         ",":     k = KIND_COMMA;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] kw_len(kw_type k);
      logic [2:0] n;
      unique case (k)
         KW_IF:    n = 3'd2;
         KW_ELSE:  n = 3'd4;
         KW_WHILE: n = 3'd5;
         KW_FOR:   n = 3'd3;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

   // character i of keyword k, zero past its end
   function automatic logic [BYTE_W-1:0] kw_char(kw_type k, logic [2:0] i);
      logic [39:0]       w;
      logic [2:0]        n;
      logic [BYTE_W-1:0] c;
      unique case (k)
         KW_IF:    w = 40'("if");
         KW_ELSE:  w = 40'("else");
         KW_WHILE: w = 40'("while");
         KW_FOR:   w = 40'("for");
         default:  w = '0;
      endcase
      n = kw_len(k);
      if (i < n) begin
         c = w[8*(int'(n) - 1 - int'(i)) +: 8];
      end else begin
         c = 8'h00;
      end
      return c;
   endfunction

endpackage

@@ rtl/kls_ram.sv @@
// kls_ram: generic single write port, single read port ram with registered read
// no dependencies

module kls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/kls_ctrl.sv @@
// kls_ctrl: sequencing state machine for the keyword lexer
// depends on kls_pkg

module kls_ctrl import kls_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      post_ff, post_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         post_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      post_in   = post_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (status.cont) begin
               cmd.append = 1'b1;
               if (status.will_fill) begin
                  cmd.rd_start = 1'b1;
                  post_in      = 1'b0;
                  state_in     = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (status.pend_active) begin
               cmd.rd_start = 1'b1;
               post_in      = 1'b1;
               state_in     = ST_READ;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHAR;
         end
         ST_CHAR: begin
            rsp_valid = 1'b1;
            cmd.more  = post_ff && (status.cls == CLS_END || status.cls == CLS_OTHER);
            if (rsp_ready) begin
               if (status.token_end) begin
                  cmd.clear = 1'b1;
                  state_in  = post_ff ? ST_POST : ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_POST: begin
            unique case (status.cls)
               CLS_END, CLS_OTHER: state_in = ST_TOKEN;
               CLS_DIGIT, CLS_ALPHA: begin
                  cmd.start = 1'b1;
                  state_in  = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_TOKEN: begin
            rsp_valid     = 1'b1;
            cmd.sel_token = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ rtl/kls_dp.sv @@
// kls_dp: token text store, keyword match tracking and result payload
// depends on kls_pkg and kls_ram

module kls_dp import kls_pkg::*; #(
   parameter int MAX_TOKEN = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [BYTE_W-1:0]   req_ch,
   input  cmd_type             cmd,
   output status_type          status,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [BYTE_W-1:0]   rsp_text_char,
   output logic                rsp_token_end,
   output logic                rsp_last
);

   localparam int DEPTH = MAX_TOKEN - 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_TOKEN);

   logic [BYTE_W-1:0] ch_ff;
   logic [CW-1:0]     count_ff, count_in;
   pend_type          pend_ff, pend_in;
   logic [NUM_KW-1:0] match_ff, match_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;

   cls_type           cls;
   logic [CW-1:0]     wr_idx;
   logic              low_idx;
   logic [NUM_KW-1:0] match_new;
   logic              wr_en;
   logic [BYTE_W-1:0] rd_data;
   logic [KIND_W-1:0] flush_kind;
   logic              token_end;

   assign cls     = classify(ch_ff);
   assign wr_idx  = cmd.start ? '0 : count_ff;
   assign low_idx = (wr_idx >> 3) == '0;
   assign wr_en   = cmd.append || cmd.start;

   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         match_new[k] = (cmd.start || match_ff[k]) && low_idx &&
                        (ch_ff == kw_char(kw_type'(2'(k)), wr_idx[2:0]));
      end
   end

   always_comb begin
      count_in = count_ff;
      pend_in  = pend_ff;
      match_in = match_ff;
      priority if (wr_en) begin
         count_in = wr_idx + CW'(1);
         match_in = match_new;
         if (cmd.start) begin
            pend_in = (cls == CLS_DIGIT) ? PEND_NUM : PEND_IDENT;
         end
      end else if (cmd.clear) begin
         count_in = '0;
         pend_in  = PEND_NONE;
      end else begin
         count_in = count_ff;
         pend_in  = pend_ff;
      end
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      priority if (cmd.rd_start) begin
         rd_idx_in = '0;
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end else begin
         rd_idx_in = rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= PEND_NONE;
         match_ff <= '0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         ch_ff <= req_ch;
      end
      rd_idx_ff <= rd_idx_in;
   end

   kls_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (ch_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      priority if (pend_ff == PEND_NUM) begin
         flush_kind = KIND_NUMBER;
      end else if (match_ff[KW_IF] && count_ff == CW'(kw_len(KW_IF))) begin
         flush_kind = KIND_IF;
      end else if (match_ff[KW_ELSE] && count_ff == CW'(kw_len(KW_ELSE))) begin
         flush_kind = KIND_ELSE;
      end else if (match_ff[KW_WHILE] && count_ff == CW'(kw_len(KW_WHILE))) begin
         flush_kind = KIND_WHILE;
      end else if (match_ff[KW_FOR] && count_ff == CW'(kw_len(KW_FOR))) begin
         flush_kind = KIND_FOR;
      end else begin
         flush_kind = KIND_IDENT;
      end
   end

   assign token_end = rd_idx_ff == (count_ff - CW'(1));

   always_comb begin
      if (cmd.sel_token) begin
         rsp_kind      = byte_kind(ch_ff);
         rsp_text_char = ch_ff;
         rsp_token_end = 1'b1;
         rsp_last      = 1'b1;
      end else begin
         rsp_kind      = flush_kind;
         rsp_text_char = rd_data;
         rsp_token_end = token_end;
         rsp_last      = token_end && !cmd.more;
      end
   end

   assign status.cls         = cls;
   assign status.pend_active = pend_ff != PEND_NONE;
   assign status.cont        = (pend_ff == PEND_NUM && cls == CLS_DIGIT) ||
                               (pend_ff == PEND_IDENT &&
                                (cls == CLS_DIGIT || cls == CLS_ALPHA));
   assign status.will_fill   = count_ff == CW'(MAX_TOKEN - 2);
   assign status.token_end   = token_end;

endmodule

@@ rtl/keyword_lexer_stream.sv @@
// keyword_lexer_stream: byte-serial lexer, one input byte per beat, one token character per beat
// steps: a byte that extends a token is accepted, then decided; any other byte is
// accepted, decided and posted, plus a token beat if it is punctuation or end; a flush
// reads each character from ram, then gives its result beat; one byte is taken at a time
// reset: synchronous, clears the controller and the pending token; text ram is not cleared
// depends on kls_pkg, kls_ctrl, kls_dp, kls_ram

module keyword_lexer_stream import kls_pkg::*; #(
   parameter int MAX_TOKEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_ch,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        rsp_kind,
   output logic [7:0]        rsp_text_char,
   output logic              rsp_token_end,
   output logic              rsp_last
);

   cmd_type    cmd;
   status_type status;

   kls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kls_dp #(
      .MAX_TOKEN (MAX_TOKEN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .cmd           (cmd),
      .status        (status),
      .rsp_kind      (rsp_kind),
      .rsp_text_char (rsp_text_char),
      .rsp_token_end (rsp_token_end),
      .rsp_last      (rsp_last)
   );

endmodule

@@ tb/tb_keyword_lexer_stream.sv @@
// tb_keyword_lexer_stream: self-checking bench for the byte-serial keyword lexer
// feeds source bytes over req_*, predicts each token character beat and checks rsp_* in order
// depends on kls_pkg and keyword_lexer_stream

module tb_keyword_lexer_stream;
   timeunit 1ns;
   timeprecision 1ps;

   import kls_pkg::*;

   localparam int MAX_TOKEN   = 32;
   localparam int STORE_LEN   = MAX_TOKEN - 1;
   localparam int PHASE_ITEMS = 42;
   localparam int HOLD_LEN    = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL        = 150;

   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] text_char;
      logic       token_end;
      logic       last;
   } tok_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [4:0] rsp_kind;
   logic [7:0] rsp_text_char;
   logic       rsp_token_end;
   logic       rsp_last;

   logic [7:0]   source_bytes [$];
   tok_char_type token_char_q [$];

   // lexer state as predicted
   logic [7:0] tok_text [0:STORE_LEN-1];
   int         tok_len = 0;
   pend_type   tok_pend = PEND_NONE;

   int         send_idle = 13;
   int         rcv_idle = 63;
   int         counted = 0;
   int         errors = 0;
   int         ch_beats = 0;
   int         hold_cnt = 0;
   logic       hold_done = 1'b0;
   int         quiet = 0;

   string      near_words [10] = '{"if", "else", "while", "for", "iff", "els", "fo",
                                   "whilex", "IF", "For"};

   keyword_lexer_stream #(
      .MAX_TOKEN(MAX_TOKEN)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ch(req_ch),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_text_char(rsp_text_char),
      .rsp_token_end(rsp_token_end),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic cls_type byte_class(input logic [7:0] c);
      cls_type r;
      r = CLS_OTHER;
      if (c == 8'h00) begin
         r = CLS_END;
      end else if (c >= "0" && c <= "9") begin
         r = CLS_DIGIT;
      end else if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z") begin
         r = CLS_ALPHA;
      end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
         r = CLS_SPACE;
      end
      return r;
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "=":     k = KIND_ASSIGN;
         ";":     k = KIND_SEMI;
         ":":     k = KIND_COLON;
         ",":     k = KIND_COMMA;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic spells(input string w);
      logic ok;
      ok = (tok_len == w.len());
      for (int i = 0; ok && i < tok_len; i++) begin
         if (tok_text[i] != w[i]) ok = 1'b0;
      end
      return ok;
   endfunction

   task automatic push_beat(input logic [4:0] kind, input logic [7:0] c, input logic tend);
      tok_char_type b;
      b.kind      = kind;
      b.text_char = c;
      b.token_end = tend;
      b.last      = 1'b0;
      token_char_q.push_back(b);
   endtask

   task automatic flush_pending();
      logic [4:0] kind;
      if (tok_pend != PEND_NONE && tok_len != 0) begin
         if (tok_pend == PEND_NUM) kind = KIND_NUMBER;
         else if (spells("if")) kind = KIND_IF;
         else if (spells("else")) kind = KIND_ELSE;
         else if (spells("while")) kind = KIND_WHILE;
         else if (spells("for")) kind = KIND_FOR;
         else kind = KIND_IDENT;
         for (int i = 0; i < tok_len; i++) begin
            push_beat(kind, tok_text[i], i == tok_len - 1);
         end
      end
      tok_pend = PEND_NONE;
      tok_len  = 0;
   endtask

   task automatic add_char(input logic [7:0] c);
      if (tok_len < STORE_LEN) begin
         tok_text[tok_len] = c;
         tok_len++;
      end
      // a full store goes out at once
      if (tok_len >= STORE_LEN) flush_pending();
   endtask

   task automatic lex_byte(input logic [7:0] c);
      cls_type      cls;
      int           prior_cnt;
      tok_char_type b;
      logic         cont;
      cls       = byte_class(c);
      prior_cnt = token_char_q.size();
      cont      = (tok_pend == PEND_NUM && cls == CLS_DIGIT) ||
                  (tok_pend == PEND_IDENT && (cls == CLS_DIGIT || cls == CLS_ALPHA));
      if (cont) begin
         add_char(c);
      end else begin
         flush_pending();
         case (cls)
            CLS_END: begin
               push_beat(KIND_END, 8'h00, 1'b1);
            end
            CLS_SPACE: begin
            end
            CLS_DIGIT, CLS_ALPHA: begin
               if (cls == CLS_DIGIT) tok_pend = PEND_NUM;
               else tok_pend = PEND_IDENT;
               tok_len = 0;
               add_char(c);
            end
            default: begin
               push_beat(punct_kind(c), c, 1'b1);
            end
         endcase
      end
      if (token_char_q.size() > prior_cnt) begin
         b = token_char_q.pop_back();
         b.last = 1'b1;
         token_char_q.push_back(b);
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         errors++;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      source_bytes.push_back(b);
      if (byte_class(b) != CLS_SPACE) counted++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      if ($urandom_range(1) == 0) c = 8'($urandom_range(122, 97));
      else c = 8'($urandom_range(90, 65));
      return c;
   endfunction

   task automatic push_word(input logic is_num, input int len);
      for (int i = 0; i < len; i++) begin
         if (is_num || (i != 0 && $urandom_range(9) < 3)) push_byte(8'($urandom_range(57, 48)));
         else push_byte(rand_letter());
      end
   endtask

   task automatic push_unknown();
      logic [7:0] c;
      case ($urandom_range(3))
         0: c = 8'($urandom_range(255, 128));
         1: c = 8'($urandom_range(8, 1));
         2: c = 8'($urandom_range(31, 14));
         default: begin
            c = 8'($urandom_range(127, 33));
            while (byte_class(c) != CLS_OTHER || punct_kind(c) != KIND_UNKNOWN) begin
               c = 8'($urandom_range(127, 33));
            end
         end
      endcase
      push_byte(c);
   endtask

   task automatic push_random_token();
      int    pick;
      string puncts;
      int    v;
      puncts = "+-*/()=;:,";
      pick   = $urandom_range(99);
      if (pick < 26) begin
         push_word(1'b0, $urandom_range(6, 1));
      end else if (pick < 36) begin
         push_text(near_words[$urandom_range(9)]);
      end else if (pick < 54) begin
         push_word(1'b1, $urandom_range(5, 1));
      end else if (pick < 66) begin
         push_byte(puncts[$urandom_range(9)]);
      end else if (pick < 78) begin
         v = $urandom_range(5);
         push_byte(v == 5 ? 8'd32 : 8'(9 + v));
      end else if (pick < 86) begin
         push_unknown();
      end else if (pick < 90) begin
         push_byte(8'h00);
      end else if (pick < 93) begin
         push_word($urandom_range(1), $urandom_range(35, 28));
      end else begin
         repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
      end
   endtask

   // source byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_ch    <= 8'h00;
      end else if (!req_valid || req_ready) begin
         if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
            req_valid <= 1'b1;
            req_ch    <= source_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 0;
         hold_done <= 1'b0;
      end else if (hold_cnt != 0) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt - 1;
      end else if (!hold_done && ch_beats >= 60) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= HOLD_LEN;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin : monitor
      tok_char_type want;
      if (reset) begin
         ch_beats <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            ch_beats <= ch_beats + 1;
            if (token_char_q.size() == 0) begin
               $display("%0t ns: unexpected beat, actual kind %0d char %0d end %0d last %0d",
                        $time, rsp_kind, rsp_text_char, rsp_token_end, rsp_last);
               errors++;
            end else begin
               want = token_char_q.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("text_char", want.text_char, rsp_text_char);
               check_field("token_end", want.token_end, rsp_token_end);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && req_ready) lex_byte(req_ch);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("tb_keyword_lexer_stream: errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // keywords, every punctuation byte, letter after digits, high bytes, end of input
      push_text("if+else-while*for/(9a )=;:,");
      push_byte(8'h80);
      push_byte(8'hFF);
      push_byte(8'h00);
      // full identifier then a digit, and a number running past the store
      push_word(1'b0, 31);
      push_byte("7");
      push_word(1'b1, 33);
      push_byte(" ");
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle = 63;
            rcv_idle  = 13;
         end else if (ph == 2) begin
            send_idle = 0;
            rcv_idle  = 0;
         end
         counted = 0;
         while (counted < PHASE_ITEMS) push_random_token();
         while (source_bytes.size() != 0 || req_valid) @(posedge clock);
      end
      push_byte(8'h00);
      while (source_bytes.size() != 0 || req_valid) @(posedge clock);
      while (token_char_q.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (errors == 0) begin
         $display("tb_keyword_lexer_stream: clean");
      end else begin
         $display("tb_keyword_lexer_stream: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/kls_pkg.sv
rtl/kls_ram.sv
rtl/kls_ctrl.sv
rtl/kls_dp.sv
rtl/keyword_lexer_stream.sv
tb/tb_keyword_lexer_stream.sv
